@@ design/frs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frs_pkg
// Shared types and constants for the Schlick Fresnel reflectance pipeline.
// ----------------------------------------------------------------------------
package frs_pkg;

  localparam logic [16:0] ONE_Q16   = 17'h1_0000;
  localparam logic [15:0] MAX_Q16   = 16'hFFFF;
  localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;

  localparam int unsigned SIN2_DSW  = 32;  // divisor width, sin2 divide
  localparam int unsigned SIN2_QW   = 33;  // quotient bits, sin2 divide
  localparam int unsigned R0_DSW    = 34;  // divisor width, r0 divide
  localparam int unsigned R0_QW     = 17;  // quotient bits, r0 divide
  localparam int unsigned SQ_STEPS  = 17;  // root bits
  localparam int unsigned SQ_RADW   = 34;  // radicand width (even)
  localparam int unsigned SQ_REMW   = 19;  // partial remainder width
  localparam int unsigned POW_STEPS = 4;   // x^5 = four multiply steps

  typedef struct packed {
    logic        n1gt;
    logic        tir;
    logic [16:0] cosv;
  } side_t;

  typedef struct packed {
    side_t       f;
    logic [16:0] r0;
  } sq_side_t;

  typedef struct packed {
    logic        tir;
    logic [16:0] r0;
  } pw_side_t;

endpackage

@@ design/fresnel_reflectance_schlick.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fresnel_reflectance_schlick
// Schlick Fresnel reflectance with total internal reflection test.
// ----------------------------------------------------------------------------
// Fully pipelined: one word in and one word out per cycle while the output
// is not stalled. The pipe is a chain of cells: four setup stages
// (products, dot and squares, one-minus-cos^2, n1^2*s), a 33-cell
// restoring divider for sin^2 of the transmitted angle (r0 divided in a
// parallel 17-cell chain), a 17-cell square root, four power cells for
// (1-cos)^5 and the output register. A stall on the output freezes the
// whole pipe; while a result waits on the output, s_axis_tready is low
// and no new word enters.
// ----------------------------------------------------------------------------
module fresnel_reflectance_schlick (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // eye_x, eye_y, eye_z, normal_x, normal_y, normal_z, index_from, index_to
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // reflectance
  output logic [15:0]  m_axis_tdata,
  // total_internal
  output logic [0:0]   m_axis_tuser
);
  import frs_pkg::*;

  localparam int unsigned NPIPE = 4 + SIN2_QW + SQ_STEPS + POW_STEPS;
  localparam int unsigned R0DLY = SIN2_QW - R0_QW;

  logic adv;
  logic vld_q [NPIPE];
  logic out_vld_q;
  logic [15:0] refl_q;
  logic        tir_q;

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = refl_q;
  assign m_axis_tuser  = tir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NPIPE; i++) vld_q[i] <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= s_axis_tvalid;
      for (int i = 1; i < NPIPE; i++) vld_q[i] <= vld_q[i-1];
      out_vld_q <= vld_q[NPIPE-1];
    end
  end

  // stage 1: products
  logic signed [31:0] px_q, py_q, pz_q;
  logic [15:0]        n1_q, n2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      px_q <= $signed(s_axis_tdata[15:0])  * $signed(s_axis_tdata[63:48]);
      py_q <= $signed(s_axis_tdata[31:16]) * $signed(s_axis_tdata[79:64]);
      pz_q <= $signed(s_axis_tdata[47:32]) * $signed(s_axis_tdata[95:80]);
      n1_q <= s_axis_tdata[111:96];
      n2_q <= s_axis_tdata[127:112];
    end
  end

  // stage 2: dot, clamp, index squares
  logic signed [33:0] dot;
  logic [16:0]        cos_d;
  logic [16:0] c2_q, sum_q;
  logic [15:0] diff_q;
  logic [31:0] n1sq2_q, n2sq2_q;
  logic        n1gt2_q;
  assign dot = 34'(px_q) + 34'(py_q) + 34'(pz_q);
  always_comb begin
    if (dot <= 0) cos_d = '0;
    else if (dot[33:12] > 22'(ONE_Q16)) cos_d = ONE_Q16;
    else cos_d = dot[28:12];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      c2_q    <= cos_d;
      n1sq2_q <= n1_q * n1_q;
      n2sq2_q <= n2_q * n2_q;
      n1gt2_q <= n1_q > n2_q;
      sum_q   <= 17'(n1_q) + 17'(n2_q);
      diff_q  <= (n1_q > n2_q) ? n1_q - n2_q : n2_q - n1_q;
    end
  end

  // stage 3: s = 1 - cos^2, r0 operands
  logic [33:0] csq;
  logic [32:0] s_q;
  logic [31:0] n1sq3_q, n2sq3_q, diffsq3_q;
  logic [33:0] sumsq3_q;
  logic        n1gt3_q;
  logic [16:0] c3_q;
  assign csq = 34'(c2_q) * 34'(c2_q);
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_q       <= ONE_Q32 - csq[32:0];
      n1sq3_q   <= n1sq2_q;
      n2sq3_q   <= n2sq2_q;
      n1gt3_q   <= n1gt2_q;
      c3_q      <= c2_q;
      diffsq3_q <= diff_q * diff_q;
      sumsq3_q  <= 34'(sum_q) * 34'(sum_q);
    end
  end

  // stage 4: n1^2 * s
  logic [64:0] lhs_full;
  logic [63:0] lhs_q;
  logic [31:0] n2sq4_q, diffsq4_q;
  logic [33:0] sumsq4_q;
  logic        n1gt4_q;
  logic [16:0] c4_q;
  assign lhs_full = 65'(n1sq3_q) * 65'(s_q);
  always_ff @(posedge clk_i) begin
    if (adv) begin
      lhs_q     <= lhs_full[63:0];
      n2sq4_q   <= n2sq3_q;
      n1gt4_q   <= n1gt3_q;
      c4_q      <= c3_q;
      diffsq4_q <= diffsq3_q;
      sumsq4_q  <= sumsq3_q;
    end
  end

  // TIR test and divider feeds
  logic  tir4, n2z, sumz;
  side_t side0;
  logic [63:0] dvd0;
  assign tir4  = n1gt4_q && (lhs_q > {n2sq4_q, 32'h0});
  assign n2z   = n2sq4_q == '0;
  assign sumz  = sumsq4_q == '0;
  assign dvd0  = n2z ? '0 : lhs_q;
  assign side0 = '{n1gt: n1gt4_q, tir: tir4, cosv: c4_q};

  // sin2 = n1^2 s / n2^2
  logic [SIN2_DSW-1:0] sd_dsor [SIN2_QW+1];
  logic [SIN2_DSW-1:0] sd_rem  [SIN2_QW+1];
  logic [SIN2_QW-1:0]  sd_low  [SIN2_QW+1];
  logic [SIN2_QW-1:0]  sd_quo  [SIN2_QW+1];
  assign sd_dsor[0] = n2z ? SIN2_DSW'(1) : n2sq4_q;
  assign sd_rem[0]  = SIN2_DSW'(dvd0[63:SIN2_QW]);
  assign sd_low[0]  = dvd0[SIN2_QW-1:0];
  assign sd_quo[0]  = '0;

  for (genvar k = 0; k < SIN2_QW; k++) begin : g_sdiv
    frs_div_cell #(.DSW(SIN2_DSW), .QW(SIN2_QW)) u_cell (
      .clk_i (clk_i), .en_i (adv),
      .dsor_i (sd_dsor[k]),   .rem_i (sd_rem[k]),
      .low_i  (sd_low[k]),    .quo_i (sd_quo[k]),
      .dsor_o (sd_dsor[k+1]), .rem_o (sd_rem[k+1]),
      .low_o  (sd_low[k+1]),  .quo_o (sd_quo[k+1])
    );
  end

  // r0 = diff^2 << 16 / sum^2
  logic [R0_DSW-1:0] rd_dsor [R0_QW+1];
  logic [R0_DSW-1:0] rd_rem  [R0_QW+1];
  logic [R0_QW-1:0]  rd_low  [R0_QW+1];
  logic [R0_QW-1:0]  rd_quo  [R0_QW+1];
  assign rd_dsor[0] = sumz ? R0_DSW'(1) : sumsq4_q;
  assign rd_rem[0]  = sumz ? '0 : R0_DSW'(diffsq4_q[31:1]);
  assign rd_low[0]  = sumz ? '0 : {diffsq4_q[0], 16'h0};
  assign rd_quo[0]  = '0;

  for (genvar k = 0; k < R0_QW; k++) begin : g_rdiv
    frs_div_cell #(.DSW(R0_DSW), .QW(R0_QW)) u_cell (
      .clk_i (clk_i), .en_i (adv),
      .dsor_i (rd_dsor[k]),   .rem_i (rd_rem[k]),
      .low_i  (rd_low[k]),    .quo_i (rd_quo[k]),
      .dsor_o (rd_dsor[k+1]), .rem_o (rd_rem[k+1]),
      .low_o  (rd_low[k+1]),  .quo_o (rd_quo[k+1])
    );
  end

  // alignment lines
  side_t       side_q [SIN2_QW];
  logic [16:0] r0d_q  [R0DLY];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side0;
      for (int i = 1; i < SIN2_QW; i++) side_q[i] <= side_q[i-1];
      r0d_q[0] <= rd_quo[R0_QW];
      for (int i = 1; i < R0DLY; i++) r0d_q[i] <= r0d_q[i-1];
    end
  end

  // cos_t = sqrt(1 - sin2)
  localparam int unsigned SQSBW = $bits(sq_side_t);
  logic [SQ_REMW-1:0]  sq_rem  [SQ_STEPS+1];
  logic [SQ_RADW-1:0]  sq_rad  [SQ_STEPS+1];
  logic [SQ_STEPS-1:0] sq_root [SQ_STEPS+1];
  logic [SQSBW-1:0]    sq_sb   [SQ_STEPS+1];
  sq_side_t            sq_in, sq_out;
  assign sq_in      = '{f: side_q[SIN2_QW-1], r0: r0d_q[R0DLY-1]};
  assign sq_rem[0]  = '0;
  assign sq_rad[0]  = SQ_RADW'(ONE_Q32 - sd_quo[SIN2_QW]);
  assign sq_root[0] = '0;
  assign sq_sb[0]   = sq_in;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    frs_sqrt_cell #(.SBW(SQSBW)) u_cell (
      .clk_i (clk_i), .en_i (adv),
      .rem_i (sq_rem[k]),   .rad_i (sq_rad[k]),
      .root_i (sq_root[k]), .sb_i (sq_sb[k]),
      .rem_o (sq_rem[k+1]), .rad_o (sq_rad[k+1]),
      .root_o (sq_root[k+1]), .sb_o (sq_sb[k+1])
    );
  end

  // (1 - cos)^5
  localparam int unsigned PWSBW = $bits(pw_side_t);
  logic [16:0]      cos_f;
  logic [16:0]      pw_x  [POW_STEPS+1];
  logic [16:0]      pw_p  [POW_STEPS+1];
  logic [PWSBW-1:0] pw_sb [POW_STEPS+1];
  pw_side_t         pw_in, pw_out;
  assign sq_out   = sq_sb[SQ_STEPS];
  assign cos_f    = sq_out.f.n1gt ? sq_root[SQ_STEPS] : sq_out.f.cosv;
  assign pw_x[0]  = ONE_Q16 - cos_f;
  assign pw_p[0]  = ONE_Q16 - cos_f;
  assign pw_in    = '{tir: sq_out.f.tir, r0: sq_out.r0};
  assign pw_sb[0] = pw_in;

  for (genvar k = 0; k < POW_STEPS; k++) begin : g_pow
    frs_pow_cell #(.SBW(PWSBW)) u_cell (
      .clk_i (clk_i), .en_i (adv),
      .x_i (pw_x[k]),   .p_i (pw_p[k]),   .sb_i (pw_sb[k]),
      .x_o (pw_x[k+1]), .p_o (pw_p[k+1]), .sb_o (pw_sb[k+1])
    );
  end

  // R = r0 + (1 - r0) p
  logic [33:0] fprod;
  logic [17:0] rsum;
  assign pw_out = pw_sb[POW_STEPS];
  assign fprod  = 34'(ONE_Q16 - pw_out.r0) * 34'(pw_p[POW_STEPS]);
  assign rsum   = 18'(pw_out.r0) + 18'(fprod[32:16]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tir_q  <= pw_out.tir;
      refl_q <= (pw_out.tir || rsum > 18'(MAX_Q16)) ? MAX_Q16 : rsum[15:0];
    end
  end

  a_tir_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == MAX_Q16)
    else $error("tir without saturated reflectance");
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("accepted word lost at pipe entry");
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q[NPIPE-1]) && $stable(refl_q))
    else $error("pipe moved while stalled");
  a_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NPIPE-POW_STEPS-1] && sq_out.f.n1gt && !sq_out.f.tir
      |-> sq_root[SQ_STEPS] <= ONE_Q16)
    else $error("transmitted cosine above one");
  a_r0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NPIPE-1] |-> pw_out.r0 <= ONE_Q16)
    else $error("r0 above one");
endmodule

@@ design/frs_div_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frs_div_cell
// One restoring-division step: brings down one dividend bit, emits one
// quotient bit, hands the word to the next cell.
// ----------------------------------------------------------------------------
module frs_div_cell #(
  parameter int unsigned DSW = 32,
  parameter int unsigned QW  = 33
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [DSW-1:0] dsor_i,
  input  logic [DSW-1:0] rem_i,
  input  logic [QW-1:0]  low_i,
  input  logic [QW-1:0]  quo_i,
  output logic [DSW-1:0] dsor_o,
  output logic [DSW-1:0] rem_o,
  output logic [QW-1:0]  low_o,
  output logic [QW-1:0]  quo_o
);
  logic [DSW:0]   r2;
  logic           ge;
  logic [DSW-1:0] rem_d;

  assign r2    = {rem_i, low_i[QW-1]};
  assign ge    = r2 >= {1'b0, dsor_i};
  assign rem_d = ge ? DSW'(r2 - {1'b0, dsor_i}) : DSW'(r2);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dsor_o <= dsor_i;
      rem_o  <= rem_d;
      low_o  <= {low_i[QW-2:0], 1'b0};
      quo_o  <= {quo_i[QW-2:0], ge};
    end
  end
endmodule

@@ design/frs_sqrt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frs_sqrt_cell
// One digit-by-digit square root step: takes two radicand bits, emits one
// root bit.
// ----------------------------------------------------------------------------
module frs_sqrt_cell #(
  parameter int unsigned SBW = 36
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [frs_pkg::SQ_REMW-1:0]    rem_i,
  input  logic [frs_pkg::SQ_RADW-1:0]    rad_i,
  input  logic [frs_pkg::SQ_STEPS-1:0]   root_i,
  input  logic [SBW-1:0]                 sb_i,
  output logic [frs_pkg::SQ_REMW-1:0]    rem_o,
  output logic [frs_pkg::SQ_RADW-1:0]    rad_o,
  output logic [frs_pkg::SQ_STEPS-1:0]   root_o,
  output logic [SBW-1:0]                 sb_o
);
  import frs_pkg::*;

  logic [SQ_REMW+1:0] rem4;
  logic [SQ_REMW+1:0] trial;
  logic               ge;

  assign rem4  = {rem_i, rad_i[SQ_RADW-1 -: 2]};
  assign trial = (SQ_REMW + 2)'({root_i, 2'b01});
  assign ge    = rem4 >= trial;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= ge ? SQ_REMW'(rem4 - trial) : SQ_REMW'(rem4);
      rad_o  <= {rad_i[SQ_RADW-3:0], 2'b00};
      root_o <= {root_i[SQ_STEPS-2:0], ge};
      sb_o   <= sb_i;
    end
  end
endmodule

@@ design/frs_pow_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frs_pow_cell
// One power step: p <= (p * x) >> 16 in Q1.16.
// ----------------------------------------------------------------------------
module frs_pow_cell #(
  parameter int unsigned SBW = 18
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [16:0]    x_i,
  input  logic [16:0]    p_i,
  input  logic [SBW-1:0] sb_i,
  output logic [16:0]    x_o,
  output logic [16:0]    p_o,
  output logic [SBW-1:0] sb_o
);
  logic [33:0] prod;

  assign prod = 34'(p_i) * 34'(x_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o  <= x_i;
      p_o  <= prod[32:16];
      sb_o <= sb_i;
    end
  end
endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Schlick Fresnel reflectance pipeline.
// ----------------------------------------------------------------------------
// A fixed-point predictor computes reflectance and the total internal
// reflection flag for every accepted word. Directed corner cases come
// first, then random ray hits mixing unit vectors, raw noise and index pairs
// around the critical angle. Both sides insert random gaps.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic [15:0] idx_to;
    logic [15:0] idx_from;
    logic [15:0] nz, ny, nx;
    logic [15:0] ez, ey, ex;
  } hit_t;

  typedef struct {
    logic [15:0] refl;
    logic        tir;
  } shade_t;

  class fresnel_board;
    shade_t pending[$];
    int     errors;

    function logic [63:0] isqrt(logic [63:0] v);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function shade_t shade(hit_t h);
      shade_t o;
      longint dot;
      logic [63:0] c, n1, n2, s, lhs, rhs, sin2, sum, diff, r0, x, p, r;
      dot = longint'($signed(h.ex)) * $signed(h.nx) + longint'($signed(h.ey)) * $signed(h.ny)
          + longint'($signed(h.ez)) * $signed(h.nz);
      n1 = h.idx_from;
      n2 = h.idx_to;
      if (dot <= 0) c = 0;
      else begin
        c = dot >>> 12;
        if (c > 65536) c = 65536;
      end
      if (n1 > n2) begin
        s = (64'd1 << 32) - c * c;
        lhs = n1 * n1 * s;
        rhs = (n2 * n2) << 32;
        if (lhs > rhs) begin
          o.refl = 16'hFFFF;
          o.tir = 1'b1;
          return o;
        end
        sin2 = (n2 == 0) ? 0 : lhs / (n2 * n2);
        if (sin2 > (64'd1 << 32)) sin2 = 64'd1 << 32;
        c = isqrt((64'd1 << 32) - sin2);
        if (c > 65536) c = 65536;
      end
      sum = n1 + n2;
      diff = (n1 > n2) ? n1 - n2 : n2 - n1;
      r0 = (sum == 0) ? 0 : ((diff * diff) << 16) / (sum * sum);
      if (r0 > 65536) r0 = 65536;
      x = 65536 - c;
      p = x;
      for (int i = 0; i < 4; i++) p = (p * x) >> 16;
      r = r0 + (((65536 - r0) * p) >> 16);
      if (r > 65535) r = 65535;
      o.refl = r[15:0];
      o.tir = 1'b0;
      return o;
    endfunction

    function void note_hit(hit_t h);
      pending = {pending, shade(h)};
    endfunction

    function void check_shade(logic [15:0] refl, logic tir);
      shade_t e;
      if (pending.size() == 0) begin
        $error("unexpected word: reflectance %0d total_internal %0d", refl, tir);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (refl !== e.refl) begin
        $error("reflectance: expected %0d, actual %0d", e.refl, refl);
        errors++;
      end
      if (tir !== e.tir) begin
        $error("total_internal: expected %0d, actual %0d", e.tir, tir);
        errors++;
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [15:0]  m_axis_tdata;
  logic [0:0]   m_axis_tuser;

  fresnel_board board = new();
  int unsigned  cycles = 0;
  int unsigned  hold = 0;
  bit           feeding_done = 0;

  fresnel_reflectance_schlick DUT (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 60);
    return $urandom_range(1, 3);
  endfunction

  task automatic send_hit(hit_t h);
    int g;
    g = (cycles > 2000 && cycles < 2400) ? 0 : gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tdata <= h;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_hit(h);
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] rnd_index();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($urandom_range(0, 4095));
      default: return 16'($urandom_range(4096, 12288));
    endcase
  endfunction

  function automatic hit_t rnd_hit();
    hit_t h;
    int   a;
    h = {$urandom(), $urandom(), $urandom(), $urandom()};
    if ($urandom_range(0, 3) != 0) begin
      // roughly unit vectors, normal near the eye direction
      a = $urandom_range(0, 16384);
      h.ex = a[15:0];
      h.ey = 16'($urandom_range(0, 16384 - a));
      h.ez = 16'($signed($urandom_range(0, 8000)) - 4000);
      h.nx = 16'(16384 - $urandom_range(0, 16384));
      h.ny = 16'($urandom_range(0, 12000));
      h.nz = 16'($signed($urandom_range(0, 6000)) - 3000);
    end
    h.idx_from = rnd_index();
    h.idx_to = rnd_index();
    return h;
  endfunction

  function automatic hit_t mk(logic [15:0] ex, nx, n1, n2);
    hit_t h;
    h = '0;
    h.ex = ex;
    h.nx = nx;
    h.idx_from = n1;
    h.idx_to = n2;
    return h;
  endfunction

  initial begin
    hit_t h;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    send_hit(mk(16'h4000, 16'h4000, 16'h1000, 16'h1800));
    send_hit(mk(16'h4000, 16'h4000, 16'h1800, 16'h1000));
    send_hit(mk(16'h2000, 16'h2000, 16'h1800, 16'h1000));
    send_hit(mk(16'h0800, 16'h4000, 16'h1800, 16'h1000));
    send_hit(mk(16'h4000, 16'hC000, 16'h1000, 16'h1800));
    send_hit(mk(16'h0000, 16'h0000, 16'h1000, 16'h1000));
    send_hit(mk(16'h7FFF, 16'h7FFF, 16'h2000, 16'h1000));
    send_hit(mk(16'h8000, 16'h8000, 16'hFFFF, 16'h1000));
    send_hit(mk(16'h8000, 16'h7FFF, 16'h1000, 16'hFFFF));
    send_hit(mk(16'h4000, 16'h4000, 16'h1000, 16'h0000));
    send_hit(mk(16'h2000, 16'h4000, 16'h1000, 16'h0000));
    send_hit(mk(16'h4000, 16'h4000, 16'h0000, 16'h0000));
    send_hit(mk(16'h3000, 16'h4000, 16'h0800, 16'h0400));
    send_hit(mk(16'h3000, 16'h4000, 16'h0400, 16'h0800));
    send_hit(mk(16'h0001, 16'h0001, 16'hFFFF, 16'hFFFE));
    send_hit(mk(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF));
    h = '1;
    send_hit(h);
    h = '0;
    send_hit(h);
    for (int i = 0; i < 400; i++) begin
      if (i == 200) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
        while (board.pending.size() != 0) @(negedge clk_i);
      end
      send_hit(rnd_hit());
    end
    s_axis_tvalid <= 1'b0;
    feeding_done = 1;
  end

  always @(negedge clk_i) begin
    if (hold != 0) begin
      hold <= hold - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 40) == 0) begin
      hold <= $urandom_range(10, 60);
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 2) == 0) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_shade(m_axis_tdata, m_axis_tuser[0]);
  end

  initial begin
    wait (feeding_done);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule

@@ fresnel_reflectance_schlick.f @@
design/frs_pkg.sv
design/frs_div_cell.sv
design/frs_sqrt_cell.sv
design/frs_pow_cell.sv
design/fresnel_reflectance_schlick.sv
bench/testbench.sv
